### rtl/f2rrg_pkg.sv
// package: widths, item types, sequencer states and helpers for the radix gearbox
`default_nettype none

package f2rrg_pkg;

    localparam int WORD_BITS  = 64;
    localparam int LIMB_BITS  = 51;
    localparam int MAX_LIMBS  = 8;

    localparam int CFG_W       = 4;
    localparam int LIMB_CNT_RESET = 5;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = ((LIMB_BITS + 7) / 8) * 8;

    // pending bits never reach a whole limb, so one word on top fits here
    localparam int ACC_W      = LIMB_BITS - 1 + WORD_BITS;
    localparam int ACC_CNT_W  = $clog2(ACC_W + 1);
    localparam int CNT_W      = $clog2(MAX_LIMBS + 1);

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 last;
    } word_item_t;

    typedef struct packed {
        logic                 idle;
        logic [ACC_CNT_W-1:0] acc_cnt;
    } back_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_FLUSH
    } seq_state_t;

    // register value above the supported maximum acts as the maximum
    function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (32'(c) > MAX_LIMBS)
            r = CNT_W'(MAX_LIMBS);
        else
            r = CNT_W'(c);
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/f2rrg_front.sv
// front end: accepts input words and queues them for the limb sequencer
`default_nettype none

module f2rrg_front
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [f2rrg_pkg::IN_TDATA_W-1:0]    s_tdata,   // [63:0] word_in
    input  wire logic                                s_tlast,   // word_last
    output logic                                     item_valid,
    input  wire logic                                item_ready,
    output f2rrg_pkg::word_item_t                    item
);

    f2rrg_pkg::word_item_t            fifo_reg [f2rrg_pkg::FIFO_DEPTH];
    logic [f2rrg_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [f2rrg_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [f2rrg_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic                             push, pop;
    f2rrg_pkg::word_item_t            in_item;

    assign s_tready   = (fill_reg != f2rrg_pkg::FILL_W'(f2rrg_pkg::FIFO_DEPTH));
    assign item_valid = (fill_reg != '0);
    assign item       = fifo_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    // only the low word bits of the bus carry the word
    assign in_item.word = s_tdata[f2rrg_pkg::WORD_BITS-1:0];
    assign in_item.last = s_tlast;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            if (wr_ptr_reg == f2rrg_pkg::PTR_W'(f2rrg_pkg::FIFO_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + f2rrg_pkg::PTR_W'(1);
        end
        if (pop)
        begin
            if (rd_ptr_reg == f2rrg_pkg::PTR_W'(f2rrg_pkg::FIFO_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + f2rrg_pkg::PTR_W'(1);
        end
        if (push && !pop)
            fill_next = fill_reg + f2rrg_pkg::FILL_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - f2rrg_pkg::FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

### rtl/f2rrg_back.sv
// back end: bit accumulator and limb sequencer with registered output
`default_nettype none

module f2rrg_back
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [f2rrg_pkg::CNT_W-1:0]         count,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire f2rrg_pkg::word_item_t               item,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [f2rrg_pkg::OUT_TDATA_W-1:0]        m_tdata,   // [50:0] limb_out
    output logic                                     m_tlast,   // limb_last
    output f2rrg_pkg::back_status_t                  status
);

    f2rrg_pkg::seq_state_t                state_reg, state_next;
    logic [f2rrg_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [f2rrg_pkg::ACC_CNT_W-1:0]      acc_cnt_reg, acc_cnt_next;
    logic [f2rrg_pkg::CNT_W-1:0]          emitted_reg, emitted_next;
    logic                                 last_reg, last_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [f2rrg_pkg::LIMB_BITS-1:0]      out_limb_reg, out_limb_next;
    logic                                 out_last_reg, out_last_next;

    logic                                 out_free;
    logic                                 has_room;
    logic                                 full_limb;
    logic                                 final_limb;
    logic [f2rrg_pkg::CNT_W-1:0]          emitted_inc;
    logic [f2rrg_pkg::ACC_W-1:0]          acc_shifted;

    assign out_free    = !out_valid_reg || m_tready;
    assign has_room    = (emitted_reg < count);
    assign full_limb   = (acc_cnt_reg >= f2rrg_pkg::ACC_CNT_W'(f2rrg_pkg::LIMB_BITS));
    assign emitted_inc = emitted_reg + f2rrg_pkg::CNT_W'(1);
    assign final_limb  = (emitted_inc == count);
    assign acc_shifted = acc_reg >> f2rrg_pkg::LIMB_BITS;

    assign item_ready     = (state_reg == f2rrg_pkg::ST_IDLE);
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = f2rrg_pkg::OUT_TDATA_W'(out_limb_reg);
    assign m_tlast        = out_last_reg;
    assign status.idle    = (state_reg == f2rrg_pkg::ST_IDLE);
    assign status.acc_cnt = acc_cnt_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            f2rrg_pkg::ST_IDLE:
            begin
                if (item_valid && has_room)
                    state_next = f2rrg_pkg::ST_EMIT;
            end
            f2rrg_pkg::ST_EMIT:
            begin
                if (!(has_room && full_limb))
                begin
                    if (last_reg && has_room)
                        state_next = f2rrg_pkg::ST_FLUSH;
                    else
                        state_next = f2rrg_pkg::ST_IDLE;
                end
            end
            f2rrg_pkg::ST_FLUSH:
            begin
                if (!has_room)
                    state_next = f2rrg_pkg::ST_IDLE;
            end
            default:
                state_next = f2rrg_pkg::ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb
    begin
        acc_next       = acc_reg;
        acc_cnt_next   = acc_cnt_reg;
        emitted_next   = emitted_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_limb_next  = out_limb_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            f2rrg_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (has_room)
                    begin
                        // new word goes above the pending bits
                        acc_next     = acc_reg |
                                       (f2rrg_pkg::ACC_W'(item.word) << acc_cnt_reg);
                        acc_cnt_next = acc_cnt_reg +
                                       f2rrg_pkg::ACC_CNT_W'(f2rrg_pkg::WORD_BITS);
                        last_next    = item.last;
                    end
                    else if (item.last)
                    begin
                        // dropped last word still closes the number
                        acc_next     = '0;
                        acc_cnt_next = '0;
                        emitted_next = '0;
                    end
                end
            end
            f2rrg_pkg::ST_EMIT:
            begin
                if (has_room && full_limb)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_limb_next  = acc_reg[f2rrg_pkg::LIMB_BITS-1:0];
                        out_last_next  = final_limb;
                        emitted_next   = emitted_inc;
                        if (final_limb)
                        begin
                            // count reached: pending bits are discarded
                            acc_next     = '0;
                            acc_cnt_next = '0;
                        end
                        else
                        begin
                            acc_next     = acc_shifted;
                            acc_cnt_next = acc_cnt_reg -
                                           f2rrg_pkg::ACC_CNT_W'(f2rrg_pkg::LIMB_BITS);
                        end
                    end
                end
                else if (last_reg && !has_room)
                begin
                    acc_next     = '0;
                    acc_cnt_next = '0;
                    emitted_next = '0;
                end
            end
            f2rrg_pkg::ST_FLUSH:
            begin
                if (has_room)
                begin
                    if (out_free)
                    begin
                        // partial limb first, zero padding after it
                        out_valid_next = 1'b1;
                        out_limb_next  = acc_reg[f2rrg_pkg::LIMB_BITS-1:0];
                        out_last_next  = final_limb;
                        emitted_next   = emitted_inc;
                        acc_next       = acc_shifted;
                        acc_cnt_next   = '0;
                    end
                end
                else
                begin
                    acc_next     = '0;
                    acc_cnt_next = '0;
                    emitted_next = '0;
                end
            end
            default:
            begin
                acc_next     = acc_reg;
                acc_cnt_next = acc_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= f2rrg_pkg::ST_IDLE;
            acc_reg       <= '0;
            acc_cnt_reg   <= '0;
            emitted_reg   <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            acc_cnt_reg   <= acc_cnt_next;
            emitted_reg   <= emitted_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_limb_reg <= out_limb_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

### rtl/full_to_reduced_radix_gearbox_core.sv
// top level: full-radix words in, reduced-radix limbs out
//
//   channel  dir  fields (low bit up)                 handshake
//   s_*      in   tdata: word_in[63:0]; tlast: last   tvalid/tready
//   m_*      out  tdata: limb_out[50:0], zero pad;    tvalid/tready
//                 tlast: limb_last
//   cfg_*    in   data: limb_count[3:0]               valid/ready, always ready
//
// a word with k whole limbs occupies the sequencer for a load step, one limb per
// cycle while the output is free, and an end check; with 51-bit limbs k is 1 or 2
// a last word adds a flush phase: the partial limb, then zero padding limbs, then a close step
// a two-entry word queue lets input keep flowing while limbs drain
// reset clears the queue, the accumulator, the counters and sets limb_count to 5
// a stalled output register holds the sequencer; input stalls only when the queue is full
`default_nettype none

module full_to_reduced_radix_gearbox_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [f2rrg_pkg::IN_TDATA_W-1:0]    s_tdata,   // [63:0] word_in
    input  wire logic                                s_tlast,   // word_last
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [f2rrg_pkg::OUT_TDATA_W-1:0]        m_tdata,   // [50:0] limb_out, rest zero
    output logic                                     m_tlast,   // limb_last
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [f2rrg_pkg::CFG_W-1:0]         cfg_data   // [3:0] limb_count
);

    logic [f2rrg_pkg::CFG_W-1:0]  limb_count_reg;
    logic [f2rrg_pkg::CNT_W-1:0]  count;
    logic                         item_valid;
    logic                         item_ready;
    f2rrg_pkg::word_item_t        item;
    f2rrg_pkg::back_status_t      status;

    assign cfg_ready = 1'b1;
    assign count     = f2rrg_pkg::active_count(limb_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limb_count_reg <= f2rrg_pkg::CFG_W'(f2rrg_pkg::LIMB_CNT_RESET);
        else if (cfg_valid && cfg_ready)
            limb_count_reg <= cfg_data;
    end

    f2rrg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    f2rrg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .count      (count),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .status     (status)
    );

    // pending bits never form a whole limb once a word is done
    a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
        status.idle |-> (status.acc_cnt < f2rrg_pkg::ACC_CNT_W'(f2rrg_pkg::LIMB_BITS)))
        else $error("whole limb left pending in idle sequencer");

    // a limb only appears out of the emit or flush phases
    a_limb_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!status.idle))
        else $error("limb produced while sequencer idle");

    // a full queue must offer a word to the sequencer
    a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> item_valid)
        else $error("queue full but empty toward sequencer");

    // the sequencer takes words only while idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |-> status.idle)
        else $error("word taken while sequencer busy");

endmodule

`default_nettype wire

### tb/full_to_reduced_radix_gearbox_core_tb.sv
// testbench: random and directed words through the radix gearbox, limbs checked against a predictor
`default_nettype none

typedef struct {
    logic [f2rrg_pkg::LIMB_BITS-1:0] limb;
    logic                            last;
} limb_due_t;

class limb_tracker;
    logic [f2rrg_pkg::CFG_W-1:0]     limb_count;
    logic [f2rrg_pkg::WORD_BITS-1:0] pend_bits;
    int unsigned                     pend_cnt;
    int unsigned                     emitted;
    int unsigned                     active;
    limb_due_t                       limbs_due[$];
    int unsigned                     limb_errors;

    function new();
        limb_count  = 4'(f2rrg_pkg::LIMB_CNT_RESET);
        pend_bits   = '0;
        pend_cnt    = 0;
        emitted     = 0;
        active      = 0;
        limb_errors = 0;
    endfunction

    function void set_limb_count(logic [f2rrg_pkg::CFG_W-1:0] v);
        limb_count = v;
    endfunction

    function int unsigned limbs_pending();
        return limbs_due.size();
    endfunction

    function int unsigned limbs_per_number();
        return (limb_count > f2rrg_pkg::MAX_LIMBS) ? f2rrg_pkg::MAX_LIMBS : limb_count;
    endfunction

    function void push_limb(logic [f2rrg_pkg::WORD_BITS-1:0] bits);
        limb_due_t d;
        d.limb = bits[f2rrg_pkg::LIMB_BITS-1:0];
        d.last = (emitted + 1 == active);
        limbs_due.push_back(d);
        emitted++;
    endfunction

    // returns 1 when the word is not simply dropped
    function bit take_word(logic [f2rrg_pkg::WORD_BITS-1:0] word, logic last);
        logic [f2rrg_pkg::WORD_BITS-1:0] w;
        logic [f2rrg_pkg::WORD_BITS-1:0] lo;
        int unsigned wcnt;
        int unsigned lcnt;
        int unsigned take;
        bit          used;
        active = limbs_per_number();
        w      = word;
        wcnt   = f2rrg_pkg::WORD_BITS;
        lo     = pend_bits;
        lcnt   = pend_cnt;
        used   = (emitted < active) || last;
        if (emitted < active)
        begin
            while (emitted < active && lcnt + wcnt >= f2rrg_pkg::LIMB_BITS)
            begin
                take = f2rrg_pkg::LIMB_BITS - lcnt;
                push_limb(lo | (w << lcnt));
                w    = w >> take;
                wcnt = wcnt - take;
                lo   = '0;
                lcnt = 0;
            end
            if (emitted < active)
            begin
                pend_bits = lo | (w << lcnt);
                pend_cnt  = lcnt + wcnt;
            end
            else
            begin
                pend_bits = '0;
                pend_cnt  = 0;
            end
        end
        if (last)
        begin
            // flush pending bits, then zero limbs up to the count
            while (emitted < active)
            begin
                push_limb(pend_bits);
                pend_bits = '0;
            end
            pend_bits = '0;
            pend_cnt  = 0;
            emitted   = 0;
        end
        return used;
    endfunction

    function void note_mismatch(string what);
        limb_errors++;
        if (limb_errors <= 10)
            $display("limb mismatch: %s", what);
    endfunction

    function void check_limb(logic [f2rrg_pkg::OUT_TDATA_W-1:0] data, logic last);
        limb_due_t want;
        if (limbs_due.size() == 0)
        begin
            note_mismatch($sformatf("unexpected limb %h last %b", data, last));
        end
        else
        begin
            want = limbs_due.pop_front();
            if (data[f2rrg_pkg::LIMB_BITS-1:0] !== want.limb || last !== want.last ||
                data[f2rrg_pkg::OUT_TDATA_W-1:f2rrg_pkg::LIMB_BITS] !== '0)
                note_mismatch($sformatf("expected limb %h last %b, got tdata %h last %b",
                                        want.limb, want.last, data, last));
        end
    endfunction
endclass

module full_to_reduced_radix_gearbox_core_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 64;
    localparam int PHASE_WORDS  = 55;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [f2rrg_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
    logic                                 s_tlast = 1'b0;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [f2rrg_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                                 m_tlast;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [f2rrg_pkg::CFG_W-1:0]          cfg_data = '0;

    limb_tracker tracker = new();
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          words_used = 0;
    int          cycles = 0;

    full_to_reduced_radix_gearbox_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("full_to_reduced_radix_gearbox_core_tb: errors");
            $finish;
        end
    end

    function automatic bit roll(int pct);
        return pct != 0 && $urandom_range(99) < pct;
    endfunction

    always @(posedge clk)
    begin
        m_tready <= !roll(sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_limb(m_tdata, m_tlast);
    end

    function automatic logic [63:0] pick_word();
        logic [63:0] w;
        case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            2: w = 64'(1) << $urandom_range(63);
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // one request on the word channel; tvalid stays up unless the sender idles
    task automatic send_word(input logic [63:0] w, input logic last);
        if (roll(src_idle_pct))
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (roll(src_idle_pct));
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        void'(tracker.take_word(w, last));
        words_used++;
    endtask

    task automatic send_number(input int nwords);
        for (int i = 0; i < nwords; i++)
            send_word(pick_word(), i == nwords - 1);
    endtask

    // sender holds off until every expected limb is out
    task automatic drain_limbs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.limbs_pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_limb_count(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_limb_count(v);
    endtask

    task automatic random_words(input int phase);
        int unsigned needed;
        int          target;
        bit          held;
        target = words_used + PHASE_WORDS;
        held   = 1'b0;
        while (words_used < target)
        begin
            needed = (tracker.limbs_per_number() * f2rrg_pkg::LIMB_BITS + 63) / 64;
            if ($urandom_range(99) < 75)
            begin
                if ($urandom_range(99) < 15)
                    send_number($urandom_range(needed + 1, needed + 4));
                else
                    send_number($urandom_range(1, needed + 1));
            end
            else if ($urandom_range(1))
            begin
                // run of words with no end marker, carries into the next number
                repeat ($urandom_range(1, 6))
                    send_word(pick_word(), 1'b0);
            end
            else
            begin
                send_word(pick_word(), 1'b1);
            end
            if (phase == 2 && !held && words_used > target - PHASE_WORDS / 2)
            begin
                drain_limbs();
                held = 1'b1;
            end
        end
        // close the number so the next setting starts clean
        send_word(pick_word(), 1'b1);
    endtask

    initial
    begin
        logic [3:0] counts [8];
        counts = '{4'd5, 4'd0, 4'd1, 4'd8, 4'd15, 4'd9, 4'd3, 4'd0};
        counts[7] = 4'($urandom_range(15));

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset count of five
        send_word('0, 1'b1);
        send_word('1, 1'b1);
        repeat (3)
            send_word('1, 1'b0);
        send_word('1, 1'b1);
        send_word(64'h8000_0000_0000_0001, 1'b0);
        send_word(64'h5555_5555_5555_5555, 1'b0);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        // count reached, extra words dropped, then a late last word
        repeat (7)
            send_word(pick_word(), 1'b0);
        send_word(pick_word(), 1'b1);
        send_word(64'h0000_0000_0000_0001, 1'b0);
        send_word(64'h0007_FFFF_FFFF_FFFF, 1'b1);
        send_word(64'hFFF8_0000_0000_0000, 1'b1);

        for (int p = 0; p < 8; p++)
        begin
            if (p != 0)
            begin
                drain_limbs();
                repeat (SETTLE)
                    @(posedge clk);
                write_limb_count(counts[p]);
            end
            case (p % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 61;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 61;
                end
                default:
                begin
                    src_idle_pct   = 18;
                    sink_stall_pct = 18;
                end
            endcase
            random_words(p);
        end

        drain_limbs();
        repeat (SETTLE)
            @(posedge clk);
        if (tracker.limb_errors == 0 && tracker.limbs_pending() == 0)
            $display("full_to_reduced_radix_gearbox_core_tb: clean");
        else
            $display("full_to_reduced_radix_gearbox_core_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
